/* src/mtp_pkg.sv */
// Shared types, command codes and constants for the multichannel toggle PWM unit.
// Depends on nothing; every other file of the unit uses it by scoped names.
`default_nettype none

package mtp_pkg;

   // Default structural sizes
   localparam int CHANNELS_DEFAULT  = 8;
   localparam int TIME_BITS_DEFAULT = 32;

   // Fixed field widths of the command and result channels
   localparam int CMD_BITS   = 3;
   localparam int CH_BITS    = 3;
   localparam int VALUE_BITS = 32;
   localparam int MASK_BITS  = 8;
   localparam int DUTY_BITS  = 8;

   // Register port
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_REG_BITS  = CSR_ADDR_BITS - 2;

   localparam logic [CSR_REG_BITS-1:0]  REG_DEFAULT_PERIOD   = '0;
   localparam logic [CSR_DATA_BITS-1:0] DEFAULT_PERIOD_RESET = 32'd256;

   // Command codes
   localparam logic [CMD_BITS-1:0] CMD_TICK       = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_ENABLE     = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_SET_PERIOD = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_SET_DUTY   = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_SET_HIGH   = 3'd4;

   // Status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   typedef struct packed {
      logic [CMD_BITS-1:0]   command;
      logic [CH_BITS-1:0]    channel;
      logic [VALUE_BITS-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic [MASK_BITS-1:0] levels;
      logic [MASK_BITS-1:0] enabled_mask;
      logic                 status;
   } rsp_item_type;

endpackage

`default_nettype wire

/* src/mtp_csr.sv */
// Register port of the toggle PWM unit: holds the default period register.
// Depends on mtp_pkg.
`default_nettype none

module mtp_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [mtp_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  wire logic [mtp_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic      [mtp_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                       csr_pready,
   output logic      [mtp_pkg::CSR_DATA_BITS-1:0]     default_period
);

   logic [mtp_pkg::CSR_DATA_BITS-1:0] default_period_ff;
   logic [mtp_pkg::CSR_DATA_BITS-1:0] default_period_in;
   logic [mtp_pkg::CSR_REG_BITS-1:0]  reg_index;
   logic                              write_en;

   // Byte lanes within a word are ignored
   assign reg_index  = csr_paddr[mtp_pkg::CSR_ADDR_BITS-1:2];
   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Select the next register value on a write transfer
   always_comb begin
      default_period_in = default_period_ff;
      if (write_en && reg_index == mtp_pkg::REG_DEFAULT_PERIOD) begin
         default_period_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_period_ff <= mtp_pkg::DEFAULT_PERIOD_RESET;
      end else begin
         default_period_ff <= default_period_in;
      end
   end

   // Read back
   assign csr_prdata = (reg_index == mtp_pkg::REG_DEFAULT_PERIOD) ? default_period_ff : '0;

   assign default_period = default_period_ff;

endmodule

`default_nettype wire

/* src/mtp_req_stage.sv */
// Input register of the toggle PWM unit: captures one command transfer.
// Depends on mtp_pkg.
`default_nettype none

module mtp_req_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire mtp_pkg::req_item_type req_item,
   output logic                       req_stall,
   input  wire logic                  take,
   output logic                       item_valid,
   output mtp_pkg::req_item_type      item
);

   logic                  valid_ff;
   logic                  valid_in;
   logic                  load;
   mtp_pkg::req_item_type item_ff;

   // Stall only while the held command cannot move on
   assign req_stall = valid_ff && !take;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture the payload on an accepted transfer
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

/* src/mtp_core.sv */
// Channel state and command execution of the toggle PWM unit: tick counter,
// per-channel enable, level, period, high/low time and expiry. Depends on mtp_pkg.
`default_nettype none

module mtp_core #(
   parameter int CHANNELS  = mtp_pkg::CHANNELS_DEFAULT,
   parameter int TIME_BITS = mtp_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 commit,
   input  wire mtp_pkg::req_item_type                item,
   input  wire logic [mtp_pkg::CSR_DATA_BITS-1:0]    default_period,
   output mtp_pkg::rsp_item_type                     result
);

   localparam int OUT_CH = (CHANNELS < mtp_pkg::MASK_BITS) ? CHANNELS : mtp_pkg::MASK_BITS;

   // Control state
   logic [CHANNELS-1:0]  en_ff, en_in;
   logic [CHANNELS-1:0]  level_ff, level_in;
   logic [TIME_BITS-1:0] cnt_ff, cnt_in;
   logic [TIME_BITS-1:0] cnt1_ff, cnt1_in;

   // Per-channel times, meaningful once the channel is enabled
   logic [TIME_BITS-1:0] period_ff [CHANNELS];
   logic [TIME_BITS-1:0] period_in [CHANNELS];
   logic [TIME_BITS-1:0] high_ff   [CHANNELS];
   logic [TIME_BITS-1:0] high_in   [CHANNELS];
   logic [TIME_BITS-1:0] low_ff    [CHANNELS];
   logic [TIME_BITS-1:0] low_in    [CHANNELS];
   logic [TIME_BITS-1:0] expiry_ff [CHANNELS];
   logic [TIME_BITS-1:0] expiry_in [CHANNELS];

   logic [CHANNELS-1:0]  sel;
   logic                 ch_ok;
   logic                 en_sel;
   logic [TIME_BITS-1:0] p_sel;
   logic [TIME_BITS-1:0] val_sat;
   logic [TIME_BITS-1:0] dper_sat;

   logic [mtp_pkg::DUTY_BITS-1:0]     duty;
   logic [TIME_BITS+7:0]              hi_prod;
   logic [2*mtp_pkg::DUTY_BITS-1:0]   lo_prod;
   logic [TIME_BITS-1:0]              duty_high;
   logic [TIME_BITS-1:0]              duty_low;
   logic [TIME_BITS-1:0]              direct_low;

   logic is_tick, do_enable, do_period, do_duty, do_high;
   logic status;

   // Decode the addressed channel; channels that the field cannot reach never match
   for (genvar i = 0; i < CHANNELS; i++) begin : g_sel
      assign sel[i] = (32'(item.channel) == 32'(i));
   end
   assign ch_ok  = |sel;
   assign en_sel = |(sel & en_ff);

   // Clamp 32-bit times to the time width
   if (TIME_BITS >= mtp_pkg::VALUE_BITS) begin : g_sat_wide
      assign val_sat  = TIME_BITS'(item.value);
      assign dper_sat = TIME_BITS'(default_period);
   end else begin : g_sat_narrow
      assign val_sat  = (|item.value[mtp_pkg::VALUE_BITS-1:TIME_BITS]) ?
                        '1 : item.value[TIME_BITS-1:0];
      assign dper_sat = (|default_period[mtp_pkg::CSR_DATA_BITS-1:TIME_BITS]) ?
                        '1 : default_period[TIME_BITS-1:0];
   end

   // Pick the addressed channel's period
   always_comb begin
      p_sel = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (sel[i]) begin
            p_sel = p_sel | period_ff[i];
         end
      end
   end

   // High time from duty: (period * duty) >> 8, split so nothing is lost
   assign duty      = (|item.value[mtp_pkg::VALUE_BITS-1:mtp_pkg::DUTY_BITS]) ?
                      '1 : item.value[mtp_pkg::DUTY_BITS-1:0];
   assign hi_prod   = (TIME_BITS+8)'(p_sel >> 8) * (TIME_BITS+8)'(duty);
   assign lo_prod   = (2*mtp_pkg::DUTY_BITS)'(p_sel[7:0]) * (2*mtp_pkg::DUTY_BITS)'(duty);
   assign duty_high = hi_prod[TIME_BITS-1:0] + TIME_BITS'(lo_prod[15:8]);
   assign duty_low  = p_sel - duty_high;

   // Low time from a direct high time, floored at zero
   assign direct_low = (p_sel > val_sat) ? (p_sel - val_sat) : '0;

   // Decode the command and check it against the channel state
   always_comb begin
      is_tick   = 1'b0;
      do_enable = 1'b0;
      do_period = 1'b0;
      do_duty   = 1'b0;
      do_high   = 1'b0;
      status    = mtp_pkg::STATUS_OK;
      unique case (item.command)
         mtp_pkg::CMD_TICK: begin
            is_tick = 1'b1;
         end
         mtp_pkg::CMD_ENABLE: begin
            if (!ch_ok || en_sel) status = mtp_pkg::STATUS_ERROR;
            else                  do_enable = 1'b1;
         end
         mtp_pkg::CMD_SET_PERIOD: begin
            if (!ch_ok || !en_sel) status = mtp_pkg::STATUS_ERROR;
            else                   do_period = 1'b1;
         end
         mtp_pkg::CMD_SET_DUTY: begin
            if (!ch_ok || !en_sel) status = mtp_pkg::STATUS_ERROR;
            else                   do_duty = 1'b1;
         end
         mtp_pkg::CMD_SET_HIGH: begin
            if (!ch_ok || !en_sel) status = mtp_pkg::STATUS_ERROR;
            else                   do_high = 1'b1;
         end
         default: begin
            status = mtp_pkg::STATUS_ERROR;
         end
      endcase
   end

   // Advance the counter; cnt1 always holds counter plus one
   assign cnt_in  = is_tick ? cnt1_ff : cnt_ff;
   assign cnt1_in = is_tick ? (cnt1_ff + TIME_BITS'(1)) : cnt1_ff;

   // Next state of every channel, all compared in parallel on a tick
   always_comb begin
      en_in    = en_ff;
      level_in = level_ff;
      for (int i = 0; i < CHANNELS; i++) begin
         period_in[i] = period_ff[i];
         high_in[i]   = high_ff[i];
         low_in[i]    = low_ff[i];
         expiry_in[i] = expiry_ff[i];
         if (is_tick && en_ff[i] && (expiry_ff[i] < cnt1_ff)) begin
            level_in[i]  = ~level_ff[i];
            expiry_in[i] = cnt1_ff + (level_ff[i] ? low_ff[i] : high_ff[i]);
         end
         if (sel[i]) begin
            if (do_enable) begin
               en_in[i]     = 1'b1;
               level_in[i]  = 1'b0;
               expiry_in[i] = '0;
               high_in[i]   = '0;
               low_in[i]    = '0;
               period_in[i] = dper_sat;
            end
            if (do_period) begin
               period_in[i] = val_sat;
            end
            if (do_duty) begin
               high_in[i] = duty_high;
               low_in[i]  = duty_low;
            end
            if (do_high) begin
               high_in[i] = val_sat;
               low_in[i]  = direct_low;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff    <= '0;
         level_ff <= '0;
         cnt_ff   <= '0;
         cnt1_ff  <= TIME_BITS'(1);
      end else if (commit) begin
         en_ff    <= en_in;
         level_ff <= level_in;
         cnt_ff   <= cnt_in;
         cnt1_ff  <= cnt1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         for (int i = 0; i < CHANNELS; i++) begin
            period_ff[i] <= period_in[i];
            high_ff[i]   <= high_in[i];
            low_ff[i]    <= low_in[i];
            expiry_ff[i] <= expiry_in[i];
         end
      end
   end

   // Report the state as it stands after this command
   assign result.levels       = mtp_pkg::MASK_BITS'(level_in[OUT_CH-1:0]);
   assign result.enabled_mask = mtp_pkg::MASK_BITS'(en_in[OUT_CH-1:0]);
   assign result.status       = status;

endmodule

`default_nettype wire

/* src/mtp_rsp_stage.sv */
// Result register of the toggle PWM unit: holds one result until it is taken.
// Depends on mtp_pkg.
`default_nettype none

module mtp_rsp_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire mtp_pkg::rsp_item_type result,
   output logic                       take,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output mtp_pkg::rsp_item_type      rsp_item
);

   logic                  valid_ff;
   logic                  valid_in;
   mtp_pkg::rsp_item_type item_ff;

   // Load whenever the register is empty or being drained this cycle
   assign take     = in_valid && (!valid_ff || !rsp_stall);
   assign valid_in = take || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

`default_nettype wire

/* src/multichannel_toggle_pwm_unit.sv */
// Top level of the multichannel toggle PWM unit.
// Depends on mtp_pkg, mtp_csr, mtp_req_stage, mtp_core and mtp_rsp_stage.
//
// One command (tick, enable, set period, set duty, set high time) is taken per
// clock cycle and gives exactly one result: the command is captured in an
// input register, then executed: all channels compare their expiry against
// the counter in parallel and the duty product (period times an 8-bit duty) is
// formed, and the channel state is written at the same edge that loads the
// result register, so the next command already sees its effect. Sustained
// rate is one command per cycle while the result side keeps draining; a
// stalled result holds one command in the input register and then stalls
// the command side. The default_period register sits at byte address 0 and
// should be written only while no command is in flight.
`default_nettype none

module multichannel_toggle_pwm_unit #(
   parameter int CHANNELS  = mtp_pkg::CHANNELS_DEFAULT,
   parameter int TIME_BITS = mtp_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // command channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [mtp_pkg::CMD_BITS-1:0]        req_command,
   input  wire logic [mtp_pkg::CH_BITS-1:0]         req_channel,
   input  wire logic [mtp_pkg::VALUE_BITS-1:0]      req_value,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [mtp_pkg::MASK_BITS-1:0]       rsp_levels,
   output logic      [mtp_pkg::MASK_BITS-1:0]       rsp_enabled_mask,
   output logic                                     rsp_status,
   // register port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [mtp_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [mtp_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic      [mtp_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                     csr_pready
);

   mtp_pkg::req_item_type             req_item;
   mtp_pkg::req_item_type             item;
   mtp_pkg::rsp_item_type             result;
   mtp_pkg::rsp_item_type             rsp_item;
   logic                              item_valid;
   logic                              take;
   logic [mtp_pkg::CSR_DATA_BITS-1:0] default_period;

   assign req_item.command = req_command;
   assign req_item.channel = req_channel;
   assign req_item.value   = req_value;

   mtp_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .default_period (default_period)
   );

   mtp_req_stage u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_item   (req_item),
      .req_stall  (req_stall),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   mtp_core #(
      .CHANNELS  (CHANNELS),
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .commit         (take),
      .item           (item),
      .default_period (default_period),
      .result         (result)
   );

   mtp_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (item_valid),
      .result    (result),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_levels       = rsp_item.levels;
   assign rsp_enabled_mask = rsp_item.enabled_mask;
   assign rsp_status       = rsp_item.status;

endmodule

`default_nettype wire

/* src/mtp_checker.sv */
// Port-level checks for the multichannel toggle PWM unit, bound to its top level.
// Depends on mtp_pkg and multichannel_toggle_pwm_unit.
`default_nettype none

module mtp_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_stall,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input wire logic [mtp_pkg::MASK_BITS-1:0]      rsp_levels,
   input wire logic [mtp_pkg::MASK_BITS-1:0]      rsp_enabled_mask,
   input wire logic                               rsp_status
);

   // A stalled result stays and keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_levels) &&
                                 $stable(rsp_enabled_mask) && $stable(rsp_status))
      else $error("result changed while stalled");

   // The command side stalls only behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("command stall without a stalled result");

   // A channel that was never enabled cannot be high
   a_level_enabled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_levels & ~rsp_enabled_mask) == '0)
      else $error("level high on a channel that is not enabled");

   // Nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // An accepted command is followed by a valid result
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> ##2 rsp_valid)
      else $error("no result after an accepted command");

endmodule

bind multichannel_toggle_pwm_unit mtp_checker u_mtp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_levels       (rsp_levels),
   .rsp_enabled_mask (rsp_enabled_mask),
   .rsp_status       (rsp_status)
);

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for multichannel_toggle_pwm_unit: PWM commands in, levels/mask/status out.
// Depends on mtp_pkg and the unit itself; keeps its own copy of the channel state to predict.
`timescale 1ns / 1ps

module tb_top;

   localparam logic [mtp_pkg::CMD_BITS-1:0] CMD_RESERVED_LO  = 3'd5;
   localparam logic [mtp_pkg::CMD_BITS-1:0] CMD_RESERVED_MID = 3'd6;
   localparam logic [mtp_pkg::CMD_BITS-1:0] CMD_RESERVED_HI  = 3'd7;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PRESSURE_HOLD  = 64;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic [mtp_pkg::CMD_BITS-1:0]        req_command;
   logic [mtp_pkg::CH_BITS-1:0]         req_channel;
   logic [mtp_pkg::VALUE_BITS-1:0]      req_value;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic [mtp_pkg::MASK_BITS-1:0]       rsp_levels;
   logic [mtp_pkg::MASK_BITS-1:0]       rsp_enabled_mask;
   logic                                rsp_status;
   logic                                csr_psel;
   logic                                csr_penable;
   logic                                csr_pwrite;
   logic [mtp_pkg::CSR_ADDR_BITS-1:0]   csr_paddr;
   logic [mtp_pkg::CSR_DATA_BITS-1:0]   csr_pwdata;
   logic [mtp_pkg::CSR_DATA_BITS-1:0]   csr_prdata;
   logic                                csr_pready;

   // Predicted channel state
   logic [31:0]          pwm_default_period;
   logic [31:0]          tick_count;
   logic [7:0]           ch_enabled;
   logic [7:0]           ch_level;
   logic [31:0]          ch_period [8];
   logic [31:0]          ch_high [8];
   logic [31:0]          ch_low [8];
   logic [31:0]          ch_expiry [8];

   mtp_pkg::rsp_item_type predicted_outputs [$];
   int                   mismatch_count = 0;
   int                   idle_cycles = 0;
   int                   req_gap_max = 0;
   int                   rsp_gap_max = 0;
   int                   rsp_hold_request = 0;

   multichannel_toggle_pwm_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_channel      (req_channel),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_levels       (rsp_levels),
      .rsp_enabled_mask (rsp_enabled_mask),
      .rsp_status       (rsp_status),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #2 clock = ~clock;

   // Apply one command to the predicted state and return the outputs it gives
   function automatic mtp_pkg::rsp_item_type apply_pwm_command(
         input logic [mtp_pkg::CMD_BITS-1:0]   cmd,
         input logic [mtp_pkg::CH_BITS-1:0]    ch,
         input logic [mtp_pkg::VALUE_BITS-1:0] val);
      mtp_pkg::rsp_item_type outputs;
      logic [63:0]  product;
      logic [31:0]  duty;
      logic [31:0]  high;
      int           i;
      outputs.status = mtp_pkg::STATUS_OK;
      if (cmd == mtp_pkg::CMD_TICK) begin
         // advance the counter, toggle every expired channel and reload its expiry
         tick_count = tick_count + 32'd1;
         for (i = 0; i < 8; i++) begin
            if (ch_enabled[i] && tick_count > ch_expiry[i]) begin
               ch_level[i] = ~ch_level[i];
               ch_expiry[i] = tick_count + (ch_level[i] ? ch_high[i] : ch_low[i]);
            end
         end
      end else if (cmd > mtp_pkg::CMD_SET_HIGH) begin
         outputs.status = mtp_pkg::STATUS_ERROR;
      end else if (cmd == mtp_pkg::CMD_ENABLE) begin
         if (ch_enabled[ch]) begin
            outputs.status = mtp_pkg::STATUS_ERROR;
         end else begin
            ch_enabled[ch] = 1'b1;
            ch_level[ch] = 1'b0;
            ch_expiry[ch] = '0;
            ch_high[ch] = '0;
            ch_low[ch] = '0;
            ch_period[ch] = pwm_default_period;
         end
      end else if (!ch_enabled[ch]) begin
         outputs.status = mtp_pkg::STATUS_ERROR;
      end else begin
         case (cmd)
            mtp_pkg::CMD_SET_PERIOD: begin
               ch_period[ch] = val;
            end
            mtp_pkg::CMD_SET_DUTY: begin
               // exact floor of period * duty / 256, duty clipped to 8 bits
               duty = (val > 32'd255) ? 32'd255 : val;
               product = {32'd0, ch_period[ch]} * {32'd0, duty};
               ch_high[ch] = product[39:8];
               ch_low[ch] = ch_period[ch] - product[39:8];
            end
            default: begin
               high = val;
               ch_high[ch] = high;
               ch_low[ch] = (ch_period[ch] > high) ? ch_period[ch] - high : 32'd0;
            end
         endcase
      end
      outputs.levels = ch_level;
      outputs.enabled_mask = ch_enabled;
      return outputs;
   endfunction

   // Offer one command, hold it until the transfer, then queue its prediction
   task automatic send_command(input logic [mtp_pkg::CMD_BITS-1:0]   cmd,
                               input logic [mtp_pkg::CH_BITS-1:0]    ch,
                               input logic [mtp_pkg::VALUE_BITS-1:0] val);
      int gap;
      gap = (req_gap_max > 0) ? $urandom_range(0, req_gap_max) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_channel <= ch;
      req_value   <= val;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted_outputs.push_back(apply_pwm_command(cmd, ch, val));
      @(negedge clock);
   endtask

   // Drop valid and wait until every predicted result has come out
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (predicted_outputs.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic csr_write(input logic [mtp_pkg::CSR_REG_BITS-1:0]  index,
                            input logic [mtp_pkg::CSR_DATA_BITS-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (index == mtp_pkg::REG_DEFAULT_PERIOD) pwm_default_period = data;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_read_check(input logic [mtp_pkg::CSR_REG_BITS-1:0] index);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {index, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (index == mtp_pkg::REG_DEFAULT_PERIOD && csr_prdata !== pwm_default_period) begin
         $error("default_period: expected %0h, actual %0h", pwm_default_period, csr_prdata);
         mismatch_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Edges of the command space, saturation and toggling with expiry wrap
   task automatic test_directed_cases();
      int i;
      req_gap_max = 2;
      rsp_gap_max = 2;
      csr_read_check(mtp_pkg::REG_DEFAULT_PERIOD);
      send_command(mtp_pkg::CMD_TICK, 3'd5, 32'hFFFF_FFFF);
      send_command(mtp_pkg::CMD_SET_PERIOD, 3'd3, 32'd10);
      send_command(CMD_RESERVED_HI, 3'd7, 32'hFFFF_FFFF);
      send_command(mtp_pkg::CMD_ENABLE, 3'd0, 32'd0);
      send_command(mtp_pkg::CMD_ENABLE, 3'd0, 32'd0);
      send_command(mtp_pkg::CMD_SET_DUTY, 3'd0, 32'd128);
      send_command(mtp_pkg::CMD_SET_DUTY, 3'd0, 32'd300);
      send_command(mtp_pkg::CMD_SET_DUTY, 3'd0, 32'd0);
      send_command(mtp_pkg::CMD_SET_HIGH, 3'd0, 32'd1000);
      send_command(mtp_pkg::CMD_SET_PERIOD, 3'd0, 32'd0);
      send_command(mtp_pkg::CMD_SET_DUTY, 3'd0, 32'd255);
      send_command(mtp_pkg::CMD_SET_PERIOD, 3'd0, 32'hFFFF_FFFF);
      send_command(mtp_pkg::CMD_SET_DUTY, 3'd0, 32'd255);
      send_command(mtp_pkg::CMD_SET_HIGH, 3'd0, 32'hFFFF_FFFF);
      send_command(mtp_pkg::CMD_SET_PERIOD, 3'd0, 32'd3);
      send_command(mtp_pkg::CMD_SET_HIGH, 3'd0, 32'd1);
      for (i = 0; i < 6; i++) send_command(mtp_pkg::CMD_TICK, 3'd0, 32'd0);
      // huge high time makes the expiry sum wrap below the counter
      send_command(mtp_pkg::CMD_SET_HIGH, 3'd0, 32'hFFFF_FFFF);
      send_command(mtp_pkg::CMD_TICK, 3'd2, 32'd0);
      send_command(mtp_pkg::CMD_TICK, 3'd7, 32'd0);
      send_command(CMD_RESERVED_LO, 3'd0, 32'd0);
      send_command(CMD_RESERVED_MID, 3'd0, 32'd5);
   endtask

   // Enable a fresh channel under each default period, extremes included
   task automatic test_default_period_sweep();
      logic [31:0] settings [4];
      int k;
      settings = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h8000_0000};
      for (k = 0; k < 4; k++) begin
         wait_idle();
         csr_write(mtp_pkg::REG_DEFAULT_PERIOD, settings[k]);
         csr_read_check(mtp_pkg::REG_DEFAULT_PERIOD);
         send_command(mtp_pkg::CMD_ENABLE, mtp_pkg::CH_BITS'(k + 1), $urandom);
         send_command(mtp_pkg::CMD_SET_DUTY, mtp_pkg::CH_BITS'(k + 1),
                      $urandom_range(0, 255));
         send_command(mtp_pkg::CMD_TICK, 3'd0, 32'd0);
         send_command(mtp_pkg::CMD_SET_HIGH, mtp_pkg::CH_BITS'(k + 1),
                      $urandom_range(0, 8));
         send_command(mtp_pkg::CMD_TICK, 3'd0, 32'd0);
         send_command(mtp_pkg::CMD_TICK, 3'd0, 32'd0);
      end
   endtask

   // Hold the result side off while commands keep coming, so the unit backs up
   task automatic test_output_backpressure();
      int i;
      wait_idle();
      req_gap_max = 0;
      rsp_gap_max = 0;
      rsp_hold_request = PRESSURE_HOLD;
      for (i = 0; i < 24; i++) begin
         if (i % 3 == 2)
            send_command(mtp_pkg::CMD_SET_HIGH, 3'd0, $urandom_range(0, 4));
         else
            send_command(mtp_pkg::CMD_TICK, 3'd0, $urandom);
      end
   endtask

   // Weighted random command: ticks most often and small times so channels toggle often
   task automatic random_command(output logic [mtp_pkg::CMD_BITS-1:0]   cmd,
                                 output logic [mtp_pkg::CH_BITS-1:0]    ch,
                                 output logic [mtp_pkg::VALUE_BITS-1:0] val);
      int pick;
      int shape;
      pick  = $urandom_range(0, 99);
      shape = $urandom_range(0, 9);
      ch    = mtp_pkg::CH_BITS'($urandom_range(0, 7));
      val   = $urandom;
      if (pick < 48) begin
         cmd = mtp_pkg::CMD_TICK;
      end else if (pick < 56) begin
         cmd = mtp_pkg::CMD_ENABLE;
      end else if (pick < 68) begin
         cmd = mtp_pkg::CMD_SET_PERIOD;
         if (shape < 7) val = $urandom_range(0, 24);
         else if (shape == 7) val = 32'hFFFF_FFFF;
         else if (shape == 8) val = 32'd0;
      end else if (pick < 82) begin
         cmd = mtp_pkg::CMD_SET_DUTY;
         if (shape < 7) val = $urandom_range(0, 255);
         else if (shape == 7) val = 32'd255;
         else if (shape == 8) val = 32'd0;
      end else if (pick < 95) begin
         cmd = mtp_pkg::CMD_SET_HIGH;
         if (shape < 6) val = $urandom_range(0, 24);
         else if (shape == 6) val = 32'hFFFF_FFFF;
         else if (shape == 7) val = 32'd0;
      end else begin
         cmd = mtp_pkg::CMD_BITS'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
      end
   endtask

   task automatic test_random_commands();
      logic [mtp_pkg::CMD_BITS-1:0]   cmd;
      logic [mtp_pkg::CH_BITS-1:0]    ch;
      logic [mtp_pkg::VALUE_BITS-1:0] val;
      int seg;
      int i;
      for (seg = 0; seg < 7; seg++) begin
         // new default period between segments, extremes now and then
         wait_idle();
         if (seg == 3) csr_write(mtp_pkg::REG_DEFAULT_PERIOD, 32'hFFFF_FFFF);
         else if (seg == 5) csr_write(mtp_pkg::REG_DEFAULT_PERIOD, 32'd0);
         else csr_write(mtp_pkg::REG_DEFAULT_PERIOD, $urandom_range(1, 30));
         csr_read_check(mtp_pkg::REG_DEFAULT_PERIOD);
         req_gap_max = (seg % 2) ? 4 : 0;
         rsp_gap_max = $urandom_range(0, 1) * 4;
         for (i = 0; i < 90; i++) begin
            random_command(cmd, ch, val);
            send_command(cmd, ch, val);
         end
      end
   endtask

   // Result sink: random hold-offs per result, plus a long one on request
   initial begin : result_sink
      int wait_cycles;
      rsp_stall = 1'b0;
      forever begin
         if (rsp_hold_request > 0) begin
            wait_cycles = rsp_hold_request;
            rsp_hold_request = 0;
         end else begin
            wait_cycles = (rsp_gap_max > 0) ? $urandom_range(0, rsp_gap_max) : 0;
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall == 1'b0));
         @(negedge clock);
      end
   end

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin : output_checker
      mtp_pkg::rsp_item_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (predicted_outputs.size() == 0) begin
            $error("result transfer with no command outstanding");
            mismatch_count++;
         end else begin
            want = predicted_outputs.pop_front();
            if (rsp_levels !== want.levels) begin
               $error("levels: expected %0h, actual %0h", want.levels, rsp_levels);
               mismatch_count++;
            end
            if (rsp_enabled_mask !== want.enabled_mask) begin
               $error("enabled_mask: expected %0h, actual %0h",
                      want.enabled_mask, rsp_enabled_mask);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0h, actual %0h", want.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   // End the run when nothing has moved for too long
   always @(posedge clock) begin
      if (reset === 1'b1 || (req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0) || csr_psel === 1'b1) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int i;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_command = mtp_pkg::CMD_TICK;
      req_channel = '0;
      req_value   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      pwm_default_period = mtp_pkg::DEFAULT_PERIOD_RESET;
      tick_count = '0;
      ch_enabled = '0;
      ch_level   = '0;
      for (i = 0; i < 8; i++) begin
         ch_period[i] = '0;
         ch_high[i]   = '0;
         ch_low[i]    = '0;
         ch_expiry[i] = '0;
      end
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_cases();
      test_default_period_sweep();
      test_output_backpressure();
      test_random_commands();

      // drain, then give the pipeline time to show any stray result
      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && predicted_outputs.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
